### rtl/core/i2a_pkg.sv
// i2a_pkg: shared constants, types and the digit-to-ascii function
// for the integer to ascii formatter; no dependencies
`timescale 1ns / 1ps

package i2a_pkg;

  // field widths
  localparam int DEF_WORD_BITS = 32;
  localparam int OPCODE_W      = 2;
  localparam int IN_VALUE_W    = 32;
  localparam int CHAR_W        = 8;
  localparam int NIB_W         = 4;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_DEC    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_HEX_LO = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HEX_UP = 2'd2;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [NIB_W-1:0]  NIB_TEN    = 4'd10;

  // converter control and status
  typedef struct packed {
    logic start;
    logic hex;
  } dab_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // emitter load request
  typedef struct packed {
    logic load;
    logic neg;
    logic upper;
  } emit_cmd_t;

  // one digit to its ascii code; decimal digits never reach ten
  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    begin
      base = upper ? CHAR_UP_A : CHAR_LO_A;
      if (d >= NIB_TEN) begin
        digit_char = base + {{(CHAR_W-NIB_W){1'b0}}, d - NIB_TEN};
      end else begin
        digit_char = CHAR_ZERO + {{(CHAR_W-NIB_W){1'b0}}, d};
      end
    end
  endfunction

endpackage

### rtl/core/i2a_dabble.sv
// i2a_dabble: bit-serial binary to bcd converter (shift and add three),
// with a direct nibble load for hex; uses i2a_pkg
`timescale 1ns / 1ps

module i2a_dabble import i2a_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int NDIG      = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dab_ctrl_t              ctrl,
  input  logic [WORD_BITS-1:0]   mag,
  output dab_stat_t              stat,
  output logic [NIB_W*NDIG-1:0]  digits
);

  localparam int DIG_BITS = NIB_W * NDIG;
  localparam int CNT_W    = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] sh_r, sh_nxt;
  logic [DIG_BITS-1:0]  bcd_r, bcd_nxt;
  logic [DIG_BITS-1:0]  bcd_adj;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [DIG_BITS+WORD_BITS-1:0] mag_ext;

  assign mag_ext = {{DIG_BITS{1'b0}}, mag};

  // add three to every digit of five or more, one lane per digit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd_r[i*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd_r[i*NIB_W +: NIB_W];
      end
    end
  end

  // one magnitude bit per cycle into the bcd register (decimal); hex loads the digits directly
  always_comb begin
    sh_nxt  = sh_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctrl.start) begin
      run_nxt = 1'b1;
      sh_nxt  = mag;
      if (ctrl.hex) begin
        bcd_nxt = mag_ext[DIG_BITS-1:0];
        cnt_nxt = '0;
      end else begin
        bcd_nxt = '0;
        cnt_nxt = CNT_W'(WORD_BITS);
      end
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        bcd_nxt = {bcd_adj[DIG_BITS-2:0], sh_r[WORD_BITS-1]};
        sh_nxt  = {sh_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = run_r && (cnt_r == '0);
  assign digits    = bcd_r;

endmodule

### rtl/core/i2a_emit.sv
// i2a_emit: digit shift register that drops leading zeros and, while the
// output slot is free, sends sign and one character per cycle; uses i2a_pkg
`timescale 1ns / 1ps

module i2a_emit import i2a_pkg::*; #(
  parameter int NDIG = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  emit_cmd_t             cmd,
  input  logic [NIB_W*NDIG-1:0] digits,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char_code,
  output logic                  out_last_char
);

  localparam int DIG_BITS = NIB_W * NDIG;
  localparam int LEFT_W   = $clog2(NDIG + 1);

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_SKIP  = 4'b0010,
    E_SIGN  = 4'b0100,
    E_DIGIT = 4'b1000
  } emit_state_t;

  emit_state_t         state_r, state_nxt;
  logic [DIG_BITS-1:0] dig_r, dig_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                neg_r, neg_nxt;
  logic                upper_r, upper_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic                slot_free;
  logic [NIB_W-1:0]    top_dig;
  logic                one_left;

  assign slot_free = !out_valid_r || out_ready;
  assign top_dig   = dig_r[DIG_BITS-1 -: NIB_W];
  assign one_left  = (left_r == LEFT_W'(1));

  // sequencer: skip leading zeros, then sign, then digits
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    unique case (state_r)
      E_IDLE: begin
        if (cmd.load) begin
          dig_nxt   = digits;
          left_nxt  = LEFT_W'(NDIG);
          neg_nxt   = cmd.neg;
          upper_nxt = cmd.upper;
          state_nxt = E_SKIP;
        end
      end
      E_SKIP: begin
        if (top_dig == '0 && !one_left) begin
          dig_nxt  = {dig_r[DIG_BITS-NIB_W-1:0], {NIB_W{1'b0}}};
          left_nxt = left_r - 1'b1;
        end else begin
          state_nxt = neg_r ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CHAR_MINUS;
          last_nxt      = 1'b0;
          state_nxt     = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = digit_char(top_dig, upper_r);
          last_nxt      = one_left;
          dig_nxt       = {dig_r[DIG_BITS-NIB_W-1:0], {NIB_W{1'b0}}};
          left_nxt      = left_r - 1'b1;
          if (one_left) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r   <= dig_nxt;
    left_r  <= left_nxt;
    neg_r   <= neg_nxt;
    upper_r <= upper_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
  end

  assign busy          = (state_r != E_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

endmodule

### rtl/core/integer_to_ascii_formatter_top.sv
// Integer to ascii formatter, top level: request capture, sign handling,
// bit-serial converter and character emitter; uses i2a_pkg, i2a_dabble, i2a_emit
// Decimal requests run the bit-serial add-three loop, hex requests load the
// nibbles directly; the emit shift register then skips leading zeros and sends
// the sign and one digit per cycle unless out_ready stalls it. New requests are
// taken only when both units are idle. Sync active-low reset, idle after.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top import i2a_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [IN_VALUE_W-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char_code,
  output logic                  out_last_char
);

  // bcd digits enough for 2**WORD_BITS - 1
  localparam int NDIG = (WORD_BITS * 302) / 1000 + 1;

  logic [IN_VALUE_W+WORD_BITS-1:0] value_ext;
  logic [WORD_BITS-1:0]            word;
  logic [WORD_BITS-1:0]            word_neg;
  logic                            is_dec;
  logic                            is_neg;
  logic                            accept;
  logic                            neg_r;
  logic                            upper_r;
  dab_ctrl_t                       dab_ctrl;
  dab_stat_t                       dab_stat;
  emit_cmd_t                       emit_cmd;
  logic [NIB_W*NDIG-1:0]           digits;
  logic                            emit_busy;

  // word taken to WORD_BITS, magnitude for negative decimal values
  assign value_ext = {{WORD_BITS{1'b0}}, in_value};
  assign word      = value_ext[WORD_BITS-1:0];
  assign word_neg  = ~word + {{(WORD_BITS-1){1'b0}}, 1'b1};
  assign is_dec    = (in_opcode == OP_DEC);
  assign is_neg    = is_dec && word[WORD_BITS-1];

  assign in_ready = !dab_stat.busy && !emit_busy;
  assign accept   = in_valid && in_ready;

  // sign and case held until the emitter loads
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r   <= is_neg;
      upper_r <= in_opcode[1];
    end
  end

  assign dab_ctrl.start = accept;
  assign dab_ctrl.hex   = !is_dec;

  assign emit_cmd.load  = dab_stat.done;
  assign emit_cmd.neg   = neg_r;
  assign emit_cmd.upper = upper_r;

  i2a_dabble #(
    .WORD_BITS (WORD_BITS),
    .NDIG      (NDIG)
  ) u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (dab_ctrl),
    .mag    (is_neg ? word_neg : word),
    .stat   (dab_stat),
    .digits (digits)
  );

  i2a_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (emit_cmd),
    .digits        (digits),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

### rtl/core/i2a_checker.sv
// i2a_checker: port-level assertions for the formatter top level,
// bound to integer_to_ascii_formatter_top; uses i2a_pkg
`timescale 1ns / 1ps

module i2a_checker import i2a_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [OPCODE_W-1:0]   in_opcode,
  input logic [IN_VALUE_W-1:0] in_value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CHAR_W-1:0]     out_char_code,
  input logic                  out_last_char
);

  // a waiting request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode) && $stable(in_value))
    else $error("waiting request changed");

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code)
                                && $stable(out_last_char))
    else $error("stalled output character changed");

  // one request at a time: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  // a new request is taken only once the previous text is complete
  a_text_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_char)
    else $error("ready while text incomplete");

  // the minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign marked last");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (.*);
